@@ sv/cos_pkg.sv @@
// Shared types and constants for the column occlusion span list.
// Holds the item structs, the operation codes and the sequencer states.
// No dependencies.
package cos_pkg;

  localparam int COLUMN_BITS = 12;
  localparam int VIEW_BITS   = 13;
  localparam int HALF_BITS   = 14;
  localparam int ENTRY_BITS  = 2 * HALF_BITS;
  localparam int VAL_BITS    = 16;
  localparam int MAX_RESULTS = 32;
  localparam int FCNT_BITS   = $clog2(MAX_RESULTS);

  localparam logic signed [HALF_BITS-1:0] RANGE_MIN = -14'sd8192;
  localparam logic signed [HALF_BITS-1:0] RANGE_MAX = 14'sd8191;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_SOLID = 2'd1,
    OP_PASS  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]             operation;
    logic [COLUMN_BITS-1:0] first_column;
    logic [COLUMN_BITS-1:0] last_column;
  } in_item_t;

  typedef struct packed {
    logic [COLUMN_BITS-1:0] frag_first;
    logic [COLUMN_BITS-1:0] frag_last;
    logic                   frag_valid;
    logic                   done_res;
    logic                   overflow;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_INIT0,
    ST_INIT1,
    ST_IDLE,
    ST_CLR0,
    ST_CLR1,
    ST_FRD,
    ST_FCHK,
    ST_SEVAL,
    ST_NRD,
    ST_NCHK,
    ST_WBS,
    ST_INS_RD,
    ST_INS_WR,
    ST_CMP_RD,
    ST_CMP_WR,
    ST_DONE
  } state_t;

endpackage

@@ sv/cos_ram.sv @@
// Simple dual-port memory holding the occluded ranges.
// One write port and one read port with registered read data; uses cos_pkg.
module cos_ram import cos_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [ENTRY_BITS-1:0]    wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [ENTRY_BITS-1:0]    rdata
);

  logic [ENTRY_BITS-1:0] mem [DEPTH];
  logic [ENTRY_BITS-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/cos_seq.sv @@
// Sequencer for the occlusion list: scan, emit fragments, insert and compact.
// Reads, modifies and writes back ranges held in cos_ram; uses cos_pkg.
module cos_seq import cos_pkg::*; #(
  parameter int MAX_RANGES = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  in_item_t                      in_item,
  input  logic [VIEW_BITS-1:0]          view_width,
  output logic                          out_valid,
  output out_item_t                     out_item,
  output logic                          mem_we,
  output logic [$clog2(MAX_RANGES)-1:0] mem_waddr,
  output logic [ENTRY_BITS-1:0]         mem_wdata,
  output logic [$clog2(MAX_RANGES)-1:0] mem_raddr,
  input  logic [ENTRY_BITS-1:0]         mem_rdata
);

  localparam int IW = $clog2(MAX_RANGES);
  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_RANGES);
  localparam logic [FCNT_BITS-1:0] FLIMIT = FCNT_BITS'(MAX_RESULTS - 1);

  state_t state_r, state_nxt;
  logic [1:0]                 op_r, op_nxt;
  logic signed [VAL_BITS-1:0] first_r, first_nxt;
  logic signed [VAL_BITS-1:0] last_r, last_nxt;
  logic signed [VAL_BITS-1:0] ef_r, ef_nxt;
  logic signed [VAL_BITS-1:0] el_r, el_nxt;
  logic signed [VAL_BITS-1:0] nl_r, nl_nxt;
  logic [CW-1:0]              idx_r, idx_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [IW-1:0]              s_r, s_nxt;
  logic [IW-1:0]              nx_r, nx_nxt;
  logic [FCNT_BITS-1:0]       fcnt_r, fcnt_nxt;
  logic                       ovf_r, ovf_nxt;
  logic                       out_valid_r, out_valid_nxt;
  out_item_t                  out_item_r, out_item_nxt;

  logic                       emit;
  logic                       close;
  logic signed [VAL_BITS-1:0] emit_f, emit_l;
  logic signed [VAL_BITS-1:0] rd_f, rd_l;
  logic                       solid;
  logic [CW-1:0]              gone;

  assign rd_f  = VAL_BITS'($signed(mem_rdata[ENTRY_BITS-1:HALF_BITS]));
  assign rd_l  = VAL_BITS'($signed(mem_rdata[HALF_BITS-1:0]));
  assign solid = (op_r == OP_SOLID);
  assign gone  = CW'(nx_r) - CW'(s_r);

  // State and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT0;
      cnt_r       <= CW'(2);
      out_valid_r <= 1'b0;
      ovf_r       <= 1'b0;
      fcnt_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      ovf_r       <= ovf_nxt;
      fcnt_r      <= fcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    first_r    <= first_nxt;
    last_r     <= last_nxt;
    ef_r       <= ef_nxt;
    el_r       <= el_nxt;
    nl_r       <= nl_nxt;
    idx_r      <= idx_nxt;
    s_r        <= s_nxt;
    nx_r       <= nx_nxt;
    out_item_r <= out_item_nxt;
  end

  // Next state, memory accesses and fragment requests.
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    ef_nxt    = ef_r;
    el_nxt    = el_r;
    nl_nxt    = nl_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    s_nxt     = s_r;
    nx_nxt    = nx_r;
    ovf_nxt   = ovf_r;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    emit      = 1'b0;
    close     = 1'b0;
    emit_f    = '0;
    emit_l    = '0;

    case (state_r)
      ST_INIT0, ST_CLR0: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = {RANGE_MIN, -14'sd1};
        state_nxt = (state_r == ST_INIT0) ? ST_INIT1 : ST_CLR1;
      end
      ST_INIT1, ST_CLR1: begin
        mem_we    = 1'b1;
        mem_waddr = IW'(1);
        mem_wdata = {HALF_BITS'(view_width), RANGE_MAX};
        cnt_nxt   = CW'(2);
        state_nxt = (state_r == ST_INIT1) ? ST_IDLE : ST_DONE;
      end
      ST_IDLE: begin
        if (start) begin
          op_nxt    = in_item.operation;
          first_nxt = VAL_BITS'(in_item.first_column);
          last_nxt  = VAL_BITS'(in_item.last_column);
          idx_nxt   = '0;
          ovf_nxt   = 1'b0;
          if (in_item.operation == OP_CLEAR) begin
            state_nxt = ST_CLR0;
          end else if ((in_item.operation == OP_SOLID || in_item.operation == OP_PASS) &&
                       in_item.first_column <= in_item.last_column) begin
            state_nxt = ST_FRD;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      // Find the first range that ends at or after first - 1.
      ST_FRD: begin
        mem_raddr = idx_r[IW-1:0];
        state_nxt = ST_FCHK;
      end
      ST_FCHK: begin
        if (idx_r < cnt_r - CW'(1) && rd_l < first_r - 16'sd1) begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = ST_FRD;
        end else begin
          s_nxt     = idx_r[IW-1:0];
          nx_nxt    = idx_r[IW-1:0];
          ef_nxt    = rd_f;
          el_nxt    = rd_l;
          state_nxt = ST_SEVAL;
        end
      end
      // Handle the part of the span left of the found range.
      ST_SEVAL: begin
        if (first_r < ef_r && last_r < ef_r - 16'sd1) begin
          emit   = 1'b1;
          emit_f = first_r;
          emit_l = last_r;
          if (!solid) begin
            state_nxt = ST_DONE;
          end else if (cnt_r >= FULL) begin
            ovf_nxt   = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            idx_nxt   = cnt_r;
            state_nxt = ST_INS_RD;
          end
        end else begin
          if (first_r < ef_r) begin
            emit   = 1'b1;
            emit_f = first_r;
            emit_l = ef_r - 16'sd1;
            ef_nxt = first_r;
          end
          if (last_r <= el_r) begin
            nl_nxt    = el_r;
            state_nxt = solid ? ST_WBS : ST_DONE;
          end else begin
            state_nxt = ST_NRD;
          end
        end
      end
      // Walk right over ranges that the span reaches.
      ST_NRD: begin
        if (CW'(nx_r) + CW'(1) < cnt_r) begin
          mem_raddr = nx_r + IW'(1);
          state_nxt = ST_NCHK;
        end else begin
          emit      = 1'b1;
          emit_f    = el_r + 16'sd1;
          emit_l    = last_r;
          nl_nxt    = last_r;
          state_nxt = solid ? ST_WBS : ST_DONE;
        end
      end
      ST_NCHK: begin
        emit = 1'b1;
        if (last_r >= rd_f - 16'sd1) begin
          emit_f = el_r + 16'sd1;
          emit_l = rd_f - 16'sd1;
          nx_nxt = nx_r + IW'(1);
          el_nxt = rd_l;
          if (last_r <= rd_l) begin
            nl_nxt    = rd_l;
            state_nxt = solid ? ST_WBS : ST_DONE;
          end else begin
            state_nxt = ST_NRD;
          end
        end else begin
          emit_f    = el_r + 16'sd1;
          emit_l    = last_r;
          nl_nxt    = last_r;
          state_nxt = solid ? ST_WBS : ST_DONE;
        end
      end
      // Write the merged range back, then close the gap left by swallowed ranges.
      ST_WBS: begin
        mem_we    = 1'b1;
        mem_waddr = s_r;
        mem_wdata = {ef_r[HALF_BITS-1:0], nl_r[HALF_BITS-1:0]};
        idx_nxt   = CW'(nx_r) + CW'(1);
        state_nxt = (nx_r == s_r) ? ST_DONE : ST_CMP_RD;
      end
      ST_CMP_RD: begin
        if (idx_r < cnt_r) begin
          mem_raddr = idx_r[IW-1:0];
          state_nxt = ST_CMP_WR;
        end else begin
          cnt_nxt   = cnt_r - gone;
          state_nxt = ST_DONE;
        end
      end
      ST_CMP_WR: begin
        mem_we    = 1'b1;
        mem_waddr = IW'(idx_r - gone);
        mem_wdata = mem_rdata;
        idx_nxt   = idx_r + CW'(1);
        state_nxt = ST_CMP_RD;
      end
      // Open a slot at the found position by shifting ranges right.
      ST_INS_RD: begin
        if (idx_r > CW'(s_r)) begin
          mem_raddr = IW'(idx_r - CW'(1));
          state_nxt = ST_INS_WR;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = s_r;
          mem_wdata = {first_r[HALF_BITS-1:0], last_r[HALF_BITS-1:0]};
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = ST_DONE;
        end
      end
      ST_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[IW-1:0];
        mem_wdata = mem_rdata;
        idx_nxt   = idx_r - CW'(1);
        state_nxt = ST_INS_RD;
      end
      ST_DONE: begin
        close     = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output stage: a fragment goes out unless empty or past the result limit.
  always_comb begin
    out_valid_nxt = 1'b0;
    fcnt_nxt      = fcnt_r;
    out_item_nxt  = out_item_r;
    if (state_r == ST_IDLE) begin
      fcnt_nxt = '0;
    end
    if (close) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = '{frag_first: '0, frag_last: '0, frag_valid: 1'b0,
                        done_res: 1'b1, overflow: ovf_r};
    end else if (emit && emit_f <= emit_l && fcnt_r < FLIMIT) begin
      out_valid_nxt = 1'b1;
      fcnt_nxt      = fcnt_r + FCNT_BITS'(1);
      out_item_nxt  = '{frag_first: emit_f[COLUMN_BITS-1:0],
                        frag_last: emit_l[COLUMN_BITS-1:0],
                        frag_valid: 1'b1, done_res: 1'b0, overflow: ovf_nxt};
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ sv/column_occlusion_span_list_core.sv @@
// Column occlusion span list: a sorted list of occluded column ranges kept in
// one on-chip memory and walked range by range by a sequencer.
// An item is taken when start is high and busy is low; busy then stays high
// until the closing item has been sent. A span scans the ranges to find its
// place, walks over the ranges it reaches, and moves ranges when it is
// inserted or when swallowed ranges are compacted. Results appear on out_item
// for one cycle each, marked by out_valid, and cannot be held off. After
// reset the block is busy while it writes the two boundary ranges. Write
// view_width through cfg_we/cfg_wdata only while the block is idle; it takes
// effect at the next clear.
module column_occlusion_span_list_core import cos_pkg::*; #(
  parameter int MAX_RANGES = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item,
  output logic                 out_valid,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [VIEW_BITS-1:0] cfg_wdata
);

  localparam int IW = $clog2(MAX_RANGES);

  logic [VIEW_BITS-1:0]  view_width_r;
  logic                  mem_we;
  logic [IW-1:0]         mem_waddr;
  logic [ENTRY_BITS-1:0] mem_wdata;
  logic [IW-1:0]         mem_raddr;
  logic [ENTRY_BITS-1:0] mem_rdata;

  // View width register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_width_r <= VIEW_BITS'(320);
    end else if (cfg_we) begin
      view_width_r <= cfg_wdata;
    end
  end

  // Range storage.
  cos_ram #(
    .DEPTH (MAX_RANGES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // List sequencer.
  cos_seq #(
    .MAX_RANGES (MAX_RANGES)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .view_width (view_width_r),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

endmodule
